>>> sv/circular_deque_engine_top_assert.svh
// assertion macros used by the checker of the deque engine
`ifndef CIRCULAR_DEQUE_ENGINE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_ENGINE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define CDE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define CDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/cde_pkg.sv
`default_nettype none

package cde_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 32;
  localparam int ITEM_W          = 32;
  localparam int POS_W           = 6;
  localparam int COUNT_W         = 7;
  localparam int EMIT_LIMIT      = 64;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_ITER  = 2'd2,
    OP_INDEX = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // one-hot classification of a request
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_iter;
    logic is_index;
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              right;
    logic [ITEM_W-1:0] item;
    logic [POS_W-1:0]  pos;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/cde_ram.sv
`default_nettype none

module cde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/cde_front.sv
`default_nettype none

module cde_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic                        direction,
  input  logic [cde_pkg::ITEM_W-1:0]  item_in,
  input  logic [cde_pkg::POS_W-1:0]   position_in,
  output logic                        q_push,
  output cde_pkg::cmd_t               q_cmd,
  input  logic                        q_full
);

  import cde_pkg::*;

  logic  f_valid;
  logic  f_valid_next;
  cmd_t  f_cmd;
  kind_t kind;
  logic  accept;

  // decode the operation into a one-hot kind
  always_comb begin
    kind = '0;
    case (op_t'(operation))
      OP_PUSH:  kind.is_push  = 1'b1;
      OP_POP:   kind.is_pop   = 1'b1;
      OP_ITER:  kind.is_iter  = 1'b1;
      OP_INDEX: kind.is_index = 1'b1;
      default:  kind          = '0;
    endcase
  end

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_valid && !q_full;
  assign q_cmd    = f_cmd;

  always_comb begin
    f_valid_next = f_valid;
    if (accept) begin
      f_valid_next = 1'b1;
    end else if (q_push) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd.kind  <= kind;
      f_cmd.right <= direction;
      f_cmd.item  <= item_in;
      f_cmd.pos   <= position_in;
    end
  end

endmodule

`default_nettype wire

>>> sv/cde_queue.sv
`default_nettype none

module cde_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cde_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output cde_pkg::cmd_t pop_cmd
);

  import cde_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);

  cmd_t          entry [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic          do_push;
  logic          do_pop;

  assign full    = (fill == FW'(DEPTH));
  assign valid   = (fill != '0);
  assign pop_cmd = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    fill_next = fill;
    if (do_push && !do_pop) begin
      fill_next = fill + FW'(1);
    end else if (do_pop && !do_push) begin
      fill_next = fill - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> sv/cde_back.sv
`default_nettype none

module cde_back #(
  parameter int CAPACITY    = cde_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = cde_pkg::HANDLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  cde_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          wr_en,
  output logic [$clog2(CAPACITY)-1:0]   wr_addr,
  output logic [HANDLE_BITS-1:0]        wr_data,
  output logic                          rd_en,
  output logic [$clog2(CAPACITY)-1:0]   rd_addr,
  input  logic [HANDLE_BITS-1:0]        rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cde_pkg::ITEM_W-1:0]    item_out,
  output logic [cde_pkg::POS_W-1:0]     position_out,
  output logic                          last,
  output logic [1:0]                    status,
  output logic [cde_pkg::COUNT_W-1:0]   count_out
);

  import cde_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int AW1 = AW + 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int NW  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int IW  = (HANDLE_BITS < ITEM_W) ? HANDLE_BITS : ITEM_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_EXEC   = 8'b00000010,
    S_PUSHL  = 8'b00000100,
    S_PUSHL2 = 8'b00001000,
    S_POPF   = 8'b00010000,
    S_POPB   = 8'b00100000,
    S_IDX    = 8'b01000000,
    S_ITER   = 8'b10000000
  } state_t;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW1-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= AW1'(CAPACITY)) begin
      sum = sum - AW1'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [ITEM_W-1:0] to_port(logic [HANDLE_BITS-1:0] v);
    logic [ITEM_W-1:0] r;
    r = '0;
    r[IW-1:0] = v[IW-1:0];
    return r;
  endfunction

  state_t               state;
  state_t               state_next;
  cmd_t                 c;
  cmd_t                 c_next;
  logic [AW-1:0]        head;
  logic [AW-1:0]        head_next;
  logic [AW-1:0]        head_dec;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [POS_W-1:0]     k;
  logic [POS_W-1:0]     k_next;
  logic [HANDLE_BITS-1:0] front;
  logic [HANDLE_BITS-1:0] front_next;
  logic [HANDLE_BITS-1:0] item_h;
  logic [NW-1:0]        n_ext;
  logic [NW-1:0]        pos_ext;
  logic [NW-1:0]        k_ext;
  logic [POS_W-1:0]     emit_m1;
  logic                 out_free;

  logic                 emit;
  logic [ITEM_W-1:0]    e_item;
  logic [POS_W-1:0]     e_pos;
  logic                 e_last;
  status_t              e_status;

  logic                 o_valid;
  logic [ITEM_W-1:0]    o_item;
  logic [POS_W-1:0]     o_pos;
  logic                 o_last;
  status_t              o_status;
  logic [COUNT_W-1:0]   o_count;

  always_comb begin
    item_h = '0;
    item_h[IW-1:0] = c.item[IW-1:0];
  end

  assign n_ext    = NW'(count);
  assign pos_ext  = NW'(c.pos);
  assign k_ext    = NW'(k);
  assign emit_m1  = (n_ext >= NW'(EMIT_LIMIT)) ? POS_W'(EMIT_LIMIT - 1)
                                                : POS_W'(n_ext - NW'(1));
  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
  assign out_free = !o_valid || !out_stall;

  always_comb begin
    state_next = state;
    c_next     = c;
    head_next  = head;
    count_next = count;
    k_next     = k;
    front_next = front;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head;
    wr_data    = item_h;
    rd_en      = 1'b0;
    rd_addr    = head;
    emit       = 1'b0;
    e_item     = '0;
    e_pos      = '0;
    e_last     = 1'b1;
    e_status   = ST_OK;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          c_next     = q_cmd;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (c.kind.is_push) begin
          if (n_ext >= NW'(CAPACITY)) begin
            if (out_free) begin
              emit       = 1'b1;
              e_status   = ST_FULL;
              state_next = S_IDLE;
            end
          end else if (count == '0 || c.right) begin
            if (out_free) begin
              wr_en      = 1'b1;
              emit       = 1'b1;
              count_next = count + CW'(1);
              state_next = S_IDLE;
              if (count != '0) begin
                head_next = head_dec;
                wr_addr   = head_dec;
              end
            end
          end else begin
            rd_en      = 1'b1;
            state_next = S_PUSHL;
          end
        end else if (count == '0) begin
          if (out_free) begin
            emit       = 1'b1;
            e_status   = ST_EMPTY;
            state_next = S_IDLE;
          end
        end else if (c.kind.is_pop) begin
          rd_en      = 1'b1;
          state_next = S_POPF;
        end else if (c.kind.is_index) begin
          if (pos_ext >= n_ext) begin
            if (out_free) begin
              emit       = 1'b1;
              e_status   = ST_RANGE;
              state_next = S_IDLE;
            end
          end else begin
            rd_en      = 1'b1;
            rd_addr    = slot_of(head, AW'(c.pos));
            state_next = S_IDX;
          end
        end else begin
          rd_en      = 1'b1;
          k_next     = '0;
          state_next = S_ITER;
        end
      end
      S_PUSHL: begin
        // old front copied to the back
        wr_en      = 1'b1;
        wr_addr    = slot_of(head, AW'(count));
        wr_data    = rd_data;
        state_next = S_PUSHL2;
      end
      S_PUSHL2: begin
        if (out_free) begin
          wr_en      = 1'b1;
          emit       = 1'b1;
          count_next = count + CW'(1);
          state_next = S_IDLE;
        end
      end
      S_POPF: begin
        if (!c.right && count > CW'(1)) begin
          front_next = rd_data;
          rd_en      = 1'b1;
          rd_addr    = slot_of(head, AW'(count - CW'(1)));
          state_next = S_POPB;
        end else if (out_free) begin
          emit       = 1'b1;
          e_item     = to_port(rd_data);
          count_next = count - CW'(1);
          state_next = S_IDLE;
          if (count > CW'(1)) begin
            head_next = slot_of(head, AW'(1));
          end
        end
      end
      S_POPB: begin
        if (out_free) begin
          wr_en      = 1'b1;
          wr_data    = rd_data;
          emit       = 1'b1;
          e_item     = to_port(front);
          count_next = count - CW'(1);
          state_next = S_IDLE;
        end
      end
      S_IDX: begin
        if (out_free) begin
          emit       = 1'b1;
          e_item     = to_port(rd_data);
          state_next = S_IDLE;
        end
      end
      S_ITER: begin
        if (out_free) begin
          emit   = 1'b1;
          e_item = to_port(rd_data);
          e_pos  = k;
          e_last = (k == emit_m1);
          if (k == emit_m1) begin
            state_next = S_IDLE;
          end else begin
            k_next = k + POS_W'(1);
            rd_en  = 1'b1;
            if (c.right) begin
              rd_addr = slot_of(head, AW'(k_ext + NW'(1)));
            end else begin
              rd_addr = slot_of(head, AW'(n_ext - k_ext - NW'(1)));
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      k       <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      k     <= k_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (!out_stall) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    c     <= c_next;
    front <= front_next;
    if (emit) begin
      o_item   <= e_item;
      o_pos    <= e_pos;
      o_last   <= e_last;
      o_status <= e_status;
      o_count  <= COUNT_W'(count_next);
    end
  end

  assign out_valid    = o_valid;
  assign item_out     = o_item;
  assign position_out = o_pos;
  assign last         = o_last;
  assign status       = o_status;
  assign count_out    = o_count;

endmodule

`default_nettype wire

>>> sv/circular_deque_engine_top.sv
// channel | handshake            | payload
// in      | in_valid / in_stall  | operation, direction, item_in, position_in
// out     | out_valid / out_stall| item_out, position_out, last, status, count_out
//
// the back end serves one request at a time from its queue; push left and pop left pass through
// extra states: push left reads the old front, copies it to the back, then writes the new item;
// pop left reads front and back, then moves the back to the front; iterate reads each slot first
// reset is synchronous and clears head, count, the queue and all valid flags; no clearing pass
// the front takes a new request while the back is busy, until the queue is full
// out_stall holds the result and the back end's next result; in_stall: queue and front both full
`default_nettype none

module circular_deque_engine_top #(
  parameter int CAPACITY    = cde_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = cde_pkg::HANDLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic                        direction,
  input  logic [cde_pkg::ITEM_W-1:0]  item_in,
  input  logic [cde_pkg::POS_W-1:0]   position_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cde_pkg::ITEM_W-1:0]  item_out,
  output logic [cde_pkg::POS_W-1:0]   position_out,
  output logic                        last,
  output logic [1:0]                  status,
  output logic [cde_pkg::COUNT_W-1:0] count_out
);

  import cde_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  // front to queue
  logic             f_push;
  cmd_t             f_cmd;
  logic             q_full;

  // queue to back end
  logic             q_valid;
  cmd_t             q_cmd;
  logic             q_pop;

  // slot store port
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [HANDLE_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [HANDLE_BITS-1:0] rd_data;

  // accepts and decodes requests
  cde_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .direction   (direction),
    .item_in     (item_in),
    .position_in (position_in),
    .q_push      (f_push),
    .q_cmd       (f_cmd),
    .q_full      (q_full)
  );

  // decouples the front from the back end
  cde_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .push_cmd (f_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  // ring sequencer with the result register
  cde_back #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_out     (item_out),
    .position_out (position_out),
    .last         (last),
    .status       (status),
    .count_out    (count_out)
  );

  // slot store, contents undefined until written
  cde_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

>>> sv/cde_chk.sv
`default_nettype none
`include "circular_deque_engine_top_assert.svh"

module cde_chk #(
  parameter int CAPACITY = cde_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [cde_pkg::ITEM_W-1:0]  item_out,
  input  logic [cde_pkg::POS_W-1:0]   position_out,
  input  logic                        last,
  input  logic [1:0]                  status,
  input  logic [cde_pkg::COUNT_W-1:0] count_out
);

  import cde_pkg::*;

  // a stalled result keeps its payload
  `CDE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(item_out) && $stable(status) && $stable(count_out), "stalled result changed")

  // error results carry no item and end their request
  `CDE_ASSERT_NOW(a_err_clean, clk, rst, out_valid && status != ST_OK, item_out == '0 && position_out == '0 && last, "error result not clean")

  // full is reported only with the ring at capacity
  `CDE_ASSERT_NOW(a_full_count, clk, rst, out_valid && status == ST_FULL, count_out == COUNT_W'(CAPACITY), "full with wrong count")

  // empty is reported only with nothing held
  `CDE_ASSERT_NOW(a_empty_count, clk, rst, out_valid && status == ST_EMPTY, count_out == '0, "empty with items held")

endmodule

bind circular_deque_engine_top cde_chk #(
  .CAPACITY (CAPACITY)
) u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .item_out     (item_out),
  .position_out (position_out),
  .last         (last),
  .status       (status),
  .count_out    (count_out)
);

`default_nettype wire

>>> tb/sv/circular_deque_engine_top_tb.sv
`timescale 1ns / 100ps

module circular_deque_engine_top_tb;
  import cde_pkg::*;

  localparam int RING_SLOTS = CAPACITY_DEF;
  localparam int RANDOM_REQUESTS = 186;

  // one result as the ring should produce it
  typedef struct {
    logic [ITEM_W-1:0]  item;
    logic [POS_W-1:0]   pos;
    logic               last;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } ring_result_t;

  // one row of the directed table; fixed rows carry their expected error result
  typedef struct {
    op_t                op;
    logic               dir;
    logic [ITEM_W-1:0]  item;
    logic [POS_W-1:0]   pos;
    logic               fixed;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } plan_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          operation;
  logic                direction;
  logic [ITEM_W-1:0]   item_in;
  logic [POS_W-1:0]    position_in;
  logic                out_valid;
  logic                out_stall;
  logic [ITEM_W-1:0]   item_out;
  logic [POS_W-1:0]    position_out;
  logic                last;
  logic [1:0]          status;
  logic [COUNT_W-1:0]  count_out;

  // shadow copy of the ring
  logic [ITEM_W-1:0]   ring_slots [RING_SLOTS];
  logic [POS_W-1:0]    ring_head;
  int                  ring_count;

  ring_result_t        awaited_results [$];
  plan_row_t           plan [24];

  bit                  no_idle;
  int                  mismatches;
  int                  results_checked;
  int                  op_seen [4];
  int                  full_hits;
  int                  longest_walk;

  circular_deque_engine_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .direction    (direction),
    .item_in      (item_in),
    .position_in  (position_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_out     (item_out),
    .position_out (position_out),
    .last         (last),
    .status       (status),
    .count_out    (count_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard limit: every request a full 64-result walk with worst stalls, several times over
  initial begin
    #60_000_000;
    $display("circular_deque_engine_top: mismatch");
    $finish;
  end

  function automatic logic [POS_W-1:0] slot_at(int k);
    logic [POS_W-1:0] s;
    s = ring_head + k[POS_W-1:0];
    return s;
  endfunction

  // applies one request to the shadow ring; queues its results when told to
  task automatic advance_ring(op_t op, logic dir, logic [ITEM_W-1:0] item,
                              logic [POS_W-1:0] pos, bit record);
    ring_result_t r;
    logic [ITEM_W-1:0] front;
    int n;
    int emit;
    int p;
    n = ring_count;
    r.item = '0;
    r.pos = '0;
    r.last = 1'b1;
    r.status = ST_OK;
    op_seen[op]++;
    if (op == OP_PUSH) begin
      if (n >= RING_SLOTS) begin
        r.status = ST_FULL;
        full_hits++;
      end else begin
        if (n == 0) begin
          ring_slots[ring_head] = item;
        end else if (dir) begin
          ring_head = ring_head - 1'b1;
          ring_slots[ring_head] = item;
        end else begin
          // old front goes to the back, new item takes the front
          front = ring_slots[slot_at(0)];
          ring_slots[slot_at(n)] = front;
          ring_slots[slot_at(0)] = item;
        end
        ring_count = n + 1;
      end
    end else if (n == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_POP) begin
      r.item = ring_slots[slot_at(0)];
      if (n > 1) begin
        if (dir) ring_head = slot_at(1);
        else ring_slots[slot_at(0)] = ring_slots[slot_at(n - 1)];
      end
      ring_count = n - 1;
    end else if (op == OP_INDEX) begin
      if (int'(pos) >= n) r.status = ST_RANGE;
      else r.item = ring_slots[slot_at(int'(pos))];
    end else begin
      // walk: rightward, or head first and then leftward from the back
      emit = (n < EMIT_LIMIT) ? n : EMIT_LIMIT;
      if (emit > longest_walk) longest_walk = emit;
      r.count = ring_count[COUNT_W-1:0];
      for (int k = 0; k < emit; k++) begin
        p = dir ? k : ((k == 0) ? 0 : n - k);
        r.item = ring_slots[slot_at(p)];
        r.pos = k[POS_W-1:0];
        r.last = (k + 1 == emit);
        if (record) awaited_results.push_back(r);
      end
      return;
    end
    r.count = ring_count[COUNT_W-1:0];
    if (record) awaited_results.push_back(r);
  endtask

  // entered and left at a falling edge
  task automatic send_request(op_t op, logic dir, logic [ITEM_W-1:0] item,
                              logic [POS_W-1:0] pos, bit fixed, status_t st,
                              logic [COUNT_W-1:0] cnt);
    ring_result_t r;
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    direction   <= dir;
    item_in     <= item;
    position_in <= pos;
    do @(posedge clk); while (in_stall);
    advance_ring(op, dir, item, pos, !fixed);
    if (fixed) begin
      r.item = '0;
      r.pos = '0;
      r.last = 1'b1;
      r.status = st;
      r.count = cnt;
      awaited_results.push_back(r);
    end
    @(negedge clk);
  endtask

  task automatic send_open(op_t op, logic dir, logic [ITEM_W-1:0] item,
                           logic [POS_W-1:0] pos);
    send_request(op, dir, item, pos, 1'b0, ST_OK, '0);
  endtask

  function automatic logic [ITEM_W-1:0] pick_item();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // result side: a fresh stall length before every result
  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    ring_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: item %h pos %0d last %0d status %0d count %0d",
                   item_out, position_out, last, status, count_out);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (item_out !== want.item || position_out !== want.pos || last !== want.last ||
            status !== want.status || count_out !== want.count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected item %h pos %0d last %0d status %0d count %0d",
                     results_checked, want.item, want.pos, want.last, want.status,
                     want.count);
            $display("  got item %h pos %0d last %0d status %0d count %0d",
                     item_out, position_out, last, status, count_out);
          end
        end
      end
    end
  end

  initial begin
    int random_sent;
    int seq_kind;
    int len;
    op_t op;
    logic [POS_W-1:0] pos;

    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = OP_PUSH;
    direction   = 1'b0;
    item_in     = '0;
    position_in = '0;
    no_idle     = 1'b0;
    mismatches  = 0;
    results_checked = 0;
    full_hits   = 0;
    longest_walk = 0;
    op_seen     = '{0, 0, 0, 0};
    ring_head   = '0;
    ring_count  = 0;

    // directed: empty ring errors, pushes both ways, index edges, walks and pops
    plan = '{
      '{OP_POP,   1'b1, 32'h0,        6'd0,  1'b1, ST_EMPTY, 7'd0},
      '{OP_POP,   1'b0, 32'h0,        6'd0,  1'b1, ST_EMPTY, 7'd0},
      '{OP_INDEX, 1'b0, 32'h0,        6'd0,  1'b1, ST_EMPTY, 7'd0},
      '{OP_ITER,  1'b1, 32'h0,        6'd0,  1'b1, ST_EMPTY, 7'd0},
      '{OP_ITER,  1'b0, 32'h0,        6'd0,  1'b1, ST_EMPTY, 7'd0},
      '{OP_PUSH,  1'b0, 32'hffffffff, 6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_PUSH,  1'b1, 32'h00000000, 6'd63, 1'b0, ST_OK,    7'd0},
      '{OP_PUSH,  1'b0, 32'ha5a5a5a5, 6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_PUSH,  1'b1, 32'h5a5a5a5a, 6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_INDEX, 1'b0, 32'h0,        6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_INDEX, 1'b1, 32'h0,        6'd3,  1'b0, ST_OK,    7'd0},
      '{OP_INDEX, 1'b0, 32'h0,        6'd4,  1'b1, ST_RANGE, 7'd4},
      '{OP_INDEX, 1'b1, 32'hffffffff, 6'd63, 1'b1, ST_RANGE, 7'd4},
      '{OP_ITER,  1'b1, 32'h0,        6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_ITER,  1'b0, 32'h0,        6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_POP,   1'b0, 32'h0,        6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_POP,   1'b1, 32'h0,        6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_ITER,  1'b0, 32'h0,        6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_POP,   1'b0, 32'h0,        6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_POP,   1'b1, 32'h0,        6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_PUSH,  1'b1, 32'h00000001, 6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_ITER,  1'b0, 32'h0,        6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_POP,   1'b0, 32'h0,        6'd0,  1'b0, ST_OK,    7'd0},
      '{OP_POP,   1'b1, 32'h0,        6'd0,  1'b1, ST_EMPTY, 7'd0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i])
      send_request(plan[i].op, plan[i].dir, plan[i].item, plan[i].pos,
                   plan[i].fixed, plan[i].status, plan[i].count);

    // random: fills to capacity, drains to empty, mixed traffic and raw noise
    random_sent = 0;
    while (random_sent < RANDOM_REQUESTS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      seq_kind = $urandom_range(0, 9);
      if (full_hits == 0 && random_sent > 120) seq_kind = 0;
      case (seq_kind)
        0, 1: begin
          while (ring_count < RING_SLOTS) begin
            send_open(OP_PUSH, 1'($urandom_range(0, 1)), pick_item(), 6'($urandom()));
            random_sent++;
          end
          repeat ($urandom_range(1, 2)) begin
            send_open(OP_PUSH, 1'($urandom_range(0, 1)), pick_item(), 6'($urandom()));
            random_sent++;
          end
          // full-length walks both ways
          send_open(OP_ITER, 1'b1, pick_item(), 6'($urandom()));
          send_open(OP_ITER, 1'b0, pick_item(), 6'($urandom()));
          random_sent += 2;
        end
        2, 3: begin
          while (ring_count > 0) begin
            send_open(OP_POP, 1'($urandom_range(0, 1)), pick_item(), 6'($urandom()));
            random_sent++;
          end
          send_open(op_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)), pick_item(),
                    6'($urandom()));
          random_sent++;
        end
        9: begin
          repeat ($urandom_range(3, 6)) begin
            send_open(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom(),
                      6'($urandom()));
            random_sent++;
          end
        end
        default: begin
          len = $urandom_range(4, 12);
          repeat (len) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4, 5, 6: op = OP_PUSH;
              7, 8, 9, 10, 11:     op = OP_POP;
              12, 13, 14, 15, 16:  op = OP_INDEX;
              default:             op = OP_ITER;
            endcase
            // index mostly inside the ring, sometimes anywhere
            if (ring_count == 0 || $urandom_range(0, 3) == 0) pos = 6'($urandom());
            else pos = 6'($urandom_range(0, ring_count - 1));
            send_open(op, 1'($urandom_range(0, 1)), pick_item(), pos);
            random_sent++;
          end
        end
      endcase
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // drain, then watch for stray results
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d requests: push %0d, pop %0d, iterate %0d, index %0d; %0d results checked",
             op_seen[OP_PUSH] + op_seen[OP_POP] + op_seen[OP_ITER] + op_seen[OP_INDEX],
             op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_ITER], op_seen[OP_INDEX],
             results_checked);
    $display("pushes refused on a full ring: %0d, longest walk: %0d results, mismatches: %0d",
             full_hits, longest_walk, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("circular_deque_engine_top: match");
    end else begin
      $display("circular_deque_engine_top: mismatch");
    end
    $finish;
  end

endmodule
